// ===== rtl/cmrb_pkg.sv =====
`default_nettype none
package cmrb_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned CountW  = 7;
  localparam int unsigned BandW   = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 8;

  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [BandW-1:0]  band_row_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOLERANCE = 3'd0,
    CFG_SAMPLE_R  = 3'd1,
    CFG_SAMPLE_G  = 3'd2,
    CFG_SAMPLE_B  = 3'd3,
    CFG_THRESHOLD = 3'd4
  } cfg_idx_e;

  localparam chan_t     TolReset       = 8'd16;
  localparam count_t    ThreshReset    = 7'd4;
  localparam count_t    CountMax       = 7'd127;
  localparam band_row_t FallbackTop    = 6'd30;
  localparam band_row_t FallbackBottom = 6'd31;

endpackage
`default_nettype wire

// ===== rtl/cmrb_pix_if.sv =====
`default_nettype none
interface cmrb_pix_if;
  import cmrb_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;
  logic  row_end;
  logic  frame_end;

  modport source (output valid, red, green, blue, row_end, frame_end, input ready);
  modport sink   (input valid, red, green, blue, row_end, frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/cmrb_band_if.sv =====
`default_nettype none
interface cmrb_band_if;
  import cmrb_pkg::*;

  logic      valid;
  logic      ready;
  band_row_t top_row;
  band_row_t bottom_row;
  logic      found;

  modport source (output valid, top_row, bottom_row, found, input ready);
  modport sink   (input valid, top_row, bottom_row, found, output ready);
endinterface
`default_nettype wire

// ===== rtl/color_match_row_band_finder.sv =====
`default_nettype none
// Color-match row band finder. Takes one RGB pixel per clock in raster order on pix_i and
// counts, per row, the pixels whose three channels each lie within color_tolerance of the
// sample color. On the pixel flagged frame_end (which also closes its row) the band result
// is loaded into the output register and shown on band_o in the next cycle: bottom_row is
// the last row with at least row_threshold matches that has a zero-count row at or above
// it, top_row is one past the nearest such zero row; otherwise 30/31 with found low. Frame
// state then clears. Throughput is one pixel per cycle, with a combinational compare and row
// counter update; pix_i stalls only while a band result waits and band_o is not ready. The user
// writes registers via cfg_we_i/cfg_idx_i/cfg_data_i only while the stream is idle; not enforced.
module color_match_row_band_finder #(
  parameter int unsigned ROWS = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [cmrb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [cmrb_pkg::CfgW-1:0]    cfg_data_i,
  cmrb_pix_if.sink                       pix_i,
  cmrb_band_if.source                    band_o
);
  import cmrb_pkg::*;

  localparam int unsigned RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [RowW-1:0] RowLast = RowW'(ROWS - 1);

  typedef logic [RowW-1:0] row_t;

  // configuration
  chan_t  tol_q, samp_r_q, samp_g_q, samp_b_q;
  count_t thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= TolReset;
      samp_r_q <= '0;
      samp_g_q <= '0;
      samp_b_q <= '0;
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TOLERANCE: tol_q    <= cfg_data_i;
        CFG_SAMPLE_R:  samp_r_q <= cfg_data_i;
        CFG_SAMPLE_G:  samp_g_q <= cfg_data_i;
        CFG_SAMPLE_B:  samp_b_q <= cfg_data_i;
        CFG_THRESHOLD: thresh_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // frame state
  count_t    count_q, count_d;
  row_t      row_q, row_d;
  row_t      zrow_q, zrow_d;
  logic      zseen_q, zseen_d;
  band_row_t top_q, top_d;
  band_row_t bot_q, bot_d;
  logic      bvalid_q, bvalid_d;

  // output register
  logic      out_valid_q, out_valid_d;
  band_row_t out_top_q, out_top_d;
  band_row_t out_bot_q, out_bot_d;
  logic      out_found_q, out_found_d;

  logic in_acc;
  logic match;
  logic close_row;
  logic count_zero, row_strong;
  count_t count_inc;
  row_t   zrow_eff;
  logic   zseen_eff;
  logic [RowW+BandW-1:0] zrow_ext, row_ext;

  function automatic logic near(chan_t a, chan_t b, chan_t tol);
    chan_t d;
    d = (a >= b) ? (a - b) : (b - a);
    return d <= tol;
  endfunction

  assign pix_i.ready = !out_valid_q || band_o.ready;
  assign in_acc      = pix_i.valid && pix_i.ready;

  assign match = near(pix_i.red, samp_r_q, tol_q) && near(pix_i.green, samp_g_q, tol_q) &&
                 near(pix_i.blue, samp_b_q, tol_q);

  assign count_inc  = (match && count_q != CountMax) ? count_q + 7'd1 : count_q;
  assign close_row  = pix_i.row_end || pix_i.frame_end;
  assign count_zero = (count_inc == '0);
  assign zrow_eff   = count_zero ? row_q : zrow_q;
  assign zseen_eff  = count_zero || zseen_q;
  assign row_strong = (count_inc >= thresh_q) && zseen_eff;
  // low six bits of row numbers, whatever the row index width
  assign zrow_ext   = {{BandW{1'b0}}, zrow_eff};
  assign row_ext    = {{BandW{1'b0}}, row_q};

  always_comb begin
    count_d     = count_q;
    row_d       = row_q;
    zrow_d      = zrow_q;
    zseen_d     = zseen_q;
    top_d       = top_q;
    bot_d       = bot_q;
    bvalid_d    = bvalid_q;
    out_valid_d = out_valid_q && !band_o.ready;
    out_top_d   = out_top_q;
    out_bot_d   = out_bot_q;
    out_found_d = out_found_q;
    if (in_acc) begin
      count_d = count_inc;
      if (close_row) begin
        count_d = '0;
        row_d   = (row_q == RowLast) ? '0 : row_q + 1'b1;
        zrow_d  = zrow_eff;
        zseen_d = zseen_eff;
        if (row_strong) begin
          top_d    = zrow_ext[BandW-1:0] + 1'b1;
          bot_d    = row_ext[BandW-1:0];
          bvalid_d = 1'b1;
        end
      end
      if (pix_i.frame_end) begin
        out_valid_d = 1'b1;
        if (row_strong) begin
          out_top_d   = zrow_ext[BandW-1:0] + 1'b1;
          out_bot_d   = row_ext[BandW-1:0];
          out_found_d = 1'b1;
        end else if (bvalid_q) begin
          out_top_d   = top_q;
          out_bot_d   = bot_q;
          out_found_d = 1'b1;
        end else begin
          out_top_d   = FallbackTop;
          out_bot_d   = FallbackBottom;
          out_found_d = 1'b0;
        end
        count_d  = '0;
        row_d    = '0;
        zrow_d   = '0;
        zseen_d  = 1'b0;
        top_d    = '0;
        bot_d    = '0;
        bvalid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      row_q       <= '0;
      zrow_q      <= '0;
      zseen_q     <= 1'b0;
      top_q       <= '0;
      bot_q       <= '0;
      bvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      row_q       <= row_d;
      zrow_q      <= zrow_d;
      zseen_q     <= zseen_d;
      top_q       <= top_d;
      bot_q       <= bot_d;
      bvalid_q    <= bvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_top_q   <= out_top_d;
    out_bot_q   <= out_bot_d;
    out_found_q <= out_found_d;
  end

  assign band_o.valid      = out_valid_q;
  assign band_o.top_row    = out_top_q;
  assign band_o.bottom_row = out_bot_q;
  assign band_o.found      = out_found_q;

endmodule
`default_nettype wire

// ===== rtl/cmrb_checker.sv =====
`default_nettype none
module cmrb_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_i,
  input wire logic                       in_frame_end_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [cmrb_pkg::BandW-1:0] out_top_i,
  input wire logic [cmrb_pkg::BandW-1:0] out_bot_i,
  input wire logic                       out_found_i
);
  import cmrb_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a pending result holds until the transaction completes
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_top_i) &&
      $stable(out_bot_i) && $stable(out_found_i))
    else $error("band result changed while stalled");

  a_fallback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_top_i == FallbackTop && out_bot_i == FallbackBottom)
    else $error("fallback rows wrong");

  a_frame_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_frame_end_i |=> out_valid_i)
    else $error("no result after frame end");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !$past(out_valid_i && !out_ready_i) |-> $past(in_acc && in_frame_end_i))
    else $error("result without frame end");

endmodule

bind color_match_row_band_finder cmrb_checker u_cmrb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (pix_i.valid),
  .in_ready_i     (pix_i.ready),
  .in_frame_end_i (pix_i.frame_end),
  .out_valid_i    (band_o.valid),
  .out_ready_i    (band_o.ready),
  .out_top_i      (band_o.top_row),
  .out_bot_i      (band_o.bottom_row),
  .out_found_i    (band_o.found)
);
`default_nettype wire
